// ===== hdl/ftp_client_control_fsm_macros.svh =====
// Assertion macros used by the checker file of the control engine.
`ifndef FTP_CLIENT_CONTROL_FSM_MACROS_SVH
`define FTP_CLIENT_CONTROL_FSM_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define FCCF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("control engine check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define FCCF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("control engine check failed");

`endif

// ===== hdl/fccf_pkg.sv =====
// Types, codes and helpers of the FTP client control engine.
package fccf_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [15:0] PORT_RESET   = 16'd6510;
  localparam logic [2:0]  OPT_CNT_RESET = 3'd1;
  localparam logic [7:0]  LF_BYTE      = 8'h0a;
  localparam logic [7:0]  ASCII_ZERO   = 8'd48;

  localparam logic signed [15:0] CODE_SVC_READY = 16'sd220;
  localparam logic signed [15:0] CODE_NEED_PASS = 16'sd331;
  localparam logic signed [15:0] CODE_LOGGED_IN = 16'sd230;
  localparam logic signed [15:0] CODE_XFER_DONE = 16'sd226;
  localparam logic signed [15:0] CODE_NO_FILE   = 16'sd550;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DATA_PORT_BASE = 2'd0,
    CFG_OPTION_COUNT   = 2'd1
  } fccf_cfg_e;

  typedef enum logic [1:0] {
    REQ_BYTE = 2'd0,
    REQ_ACK  = 2'd1,
    REQ_USER = 2'd2,
    REQ_LOST = 2'd3
  } fccf_req_e;

  typedef enum logic [1:0] {
    UCMD_LIST = 2'd0,
    UCMD_GET  = 2'd1,
    UCMD_CWD  = 2'd2,
    UCMD_CDUP = 2'd3
  } fccf_ucmd_e;

  typedef enum logic [3:0] {
    CMD_NONE   = 4'd0,
    CMD_USER   = 4'd1,
    CMD_PASS   = 4'd2,
    CMD_PORT   = 4'd3,
    CMD_OPTION = 4'd4,
    CMD_NLST   = 4'd5,
    CMD_RETR   = 4'd6,
    CMD_CWD    = 4'd7,
    CMD_CDUP   = 4'd8
  } fccf_cmd_e;

  typedef enum logic [4:0] {
    ST_NONE      = 5'd0,
    ST_INITIAL   = 5'd1,
    ST_SEND_USER = 5'd2,
    ST_USER_SENT = 5'd3,
    ST_SEND_PASS = 5'd4,
    ST_PASS_SENT = 5'd5,
    ST_SEND_PORT = 5'd6,
    ST_PORT_SENT = 5'd7,
    ST_SEND_OPT  = 5'd8,
    ST_OPT_SENT  = 5'd9,
    ST_CONNECTED = 5'd10,
    ST_SEND_NLST = 5'd11,
    ST_NLST_SENT = 5'd12,
    ST_SEND_RETR = 5'd13,
    ST_RETR_SENT = 5'd14,
    ST_SEND_CWD  = 5'd15,
    ST_CWD_SENT  = 5'd16,
    ST_SEND_CDUP = 5'd17,
    ST_CDUP_SENT = 5'd18,
    ST_SEND_QUIT = 5'd19,
    ST_QUIT_SENT = 5'd20
  } fccf_state_e;

  // Reply line status from the line capture unit.
  typedef struct packed {
    logic               line_done;
    logic signed [15:0] reply_code;
  } fccf_line_t;

  typedef struct packed {
    logic [3:0]         pending_cmd;
    logic [2:0]         option_index;
    logic [4:0]         proto_state;
    logic [15:0]        data_port;
    logic               line_done;
    logic signed [15:0] reply_code;
    logic               connected_event;
    logic               cwd_done_event;
    logic               list_end_event;
    logic               req_accepted;
  } fccf_rsp_t;

  function automatic fccf_cmd_e cmd_for_state(fccf_state_e s);
    case (s)
      ST_SEND_USER: return CMD_USER;
      ST_SEND_PASS: return CMD_PASS;
      ST_SEND_PORT: return CMD_PORT;
      ST_SEND_OPT:  return CMD_OPTION;
      ST_SEND_NLST: return CMD_NLST;
      ST_SEND_RETR: return CMD_RETR;
      ST_SEND_CWD:  return CMD_CWD;
      ST_SEND_CDUP: return CMD_CDUP;
      default:      return CMD_NONE;
    endcase
  endfunction

endpackage

// ===== hdl/fccf_if.sv =====
// Valid/ready channels for control events in and status results out.
interface fccf_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] rx_byte;
  logic [1:0] user_cmd;

  modport source (output valid, req_type, rx_byte, user_cmd, input ready);
  modport sink   (input valid, req_type, rx_byte, user_cmd, output ready);
endinterface

interface fccf_rsp_if;
  logic               valid;
  logic               ready;
  logic [3:0]         pending_cmd;
  logic [2:0]         option_index;
  logic [4:0]         proto_state;
  logic [15:0]        data_port;
  logic               line_done;
  logic signed [15:0] reply_code;
  logic               connected_event;
  logic               cwd_done_event;
  logic               list_end_event;
  logic               req_accepted;

  modport source (output valid, pending_cmd, option_index, proto_state, data_port,
                  line_done, reply_code, connected_event, cwd_done_event,
                  list_end_event, req_accepted, input ready);
  modport sink   (input valid, pending_cmd, option_index, proto_state, data_port,
                  line_done, reply_code, connected_event, cwd_done_event,
                  list_end_event, req_accepted, output ready);
endinterface

// ===== hdl/ftp_client_control_fsm.sv =====
// FTP client control engine top level: session state machine and result buffering.
//
// Takes one control event per cycle (reply byte, command acknowledge, user
// request or connection loss) and returns one status result for each
// through a result register backed by a one-entry skid stage, so a stalled
// result sink holds off new events only once both are full. Sustained rate
// is one event per cycle while the result sink keeps up; the whole update (reply
// code from the stored line bytes, compare against the known codes and the
// state select) sits between the event input and the result register.
// Configuration writes take effect at once and are meant for idle periods;
// a write of data_port_base also reloads the current data port.
module ftp_client_control_fsm import fccf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  fccf_req_if.sink              req_i,
  fccf_rsp_if.source            rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  fccf_state_e state_q, state_d;
  logic [2:0]  opt_cnt_q;
  logic [2:0]  opt_sent_q, opt_sent_d;
  logic [15:0] port_q, port_d;
  logic        rdy_rep_q, rdy_rep_d;

  logic        accept;
  fccf_req_e   req;
  fccf_line_t  line;
  fccf_rsp_t   rsp_new;
  fccf_cmd_e   cmd;

  fccf_rsp_t   out_q, skid_q;
  logic        out_v_q, skid_v_q;
  logic        pop;

  assign req_i.ready = !skid_v_q;
  assign accept      = req_i.valid && !skid_v_q;
  assign req         = fccf_req_e'(req_i.req_type);

  fccf_reply u_reply (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_vld_i (accept && (req == REQ_BYTE)),
    .rx_byte_i  (req_i.rx_byte),
    .clear_i    (accept && (req == REQ_LOST)),
    .line_o     (line)
  );

  always_comb begin
    state_d    = state_q;
    opt_sent_d = opt_sent_q;
    port_d     = port_q;
    rdy_rep_d  = rdy_rep_q;
    rsp_new    = '0;

    case (req)
      REQ_BYTE: begin
        if (line.line_done) begin
          case (state_q)
            ST_INITIAL: begin
              if (line.reply_code == CODE_SVC_READY) state_d = ST_SEND_USER;
            end
            ST_USER_SENT: begin
              if (line.reply_code == CODE_NEED_PASS) state_d = ST_SEND_PASS;
            end
            ST_PASS_SENT: begin
              if (line.reply_code == CODE_LOGGED_IN) begin
                state_d    = ST_SEND_OPT;
                opt_sent_d = 3'd0;
              end
            end
            ST_PORT_SENT: begin
              state_d = ST_CONNECTED;
              if (!rdy_rep_q) begin
                rsp_new.connected_event = 1'b1;
                rdy_rep_d               = 1'b1;
              end
            end
            ST_OPT_SENT: begin
              state_d = (opt_sent_q >= opt_cnt_q) ? ST_SEND_PORT : ST_SEND_OPT;
            end
            ST_NLST_SENT, ST_RETR_SENT, ST_CONNECTED: begin
              // bump the data port after a finished or refused transfer
              if (line.reply_code == CODE_XFER_DONE || line.reply_code == CODE_NO_FILE) begin
                port_d  = port_q + 16'd1;
                state_d = ST_SEND_PORT;
              end
              rsp_new.list_end_event = (line.reply_code == CODE_NO_FILE);
            end
            ST_CWD_SENT, ST_CDUP_SENT: begin
              state_d                = ST_CONNECTED;
              rsp_new.cwd_done_event = 1'b1;
            end
            default: ;
          endcase
        end
      end
      REQ_ACK: begin
        case (state_q)
          ST_SEND_USER: state_d = ST_USER_SENT;
          ST_SEND_PASS: state_d = ST_PASS_SENT;
          ST_SEND_PORT: state_d = ST_PORT_SENT;
          ST_SEND_OPT: begin
            opt_sent_d = opt_sent_q + 3'd1;
            state_d    = ST_OPT_SENT;
          end
          ST_SEND_NLST: state_d = ST_NLST_SENT;
          ST_SEND_RETR: state_d = ST_RETR_SENT;
          ST_SEND_CWD:  state_d = ST_CWD_SENT;
          ST_SEND_CDUP: state_d = ST_CDUP_SENT;
          ST_SEND_QUIT: state_d = ST_QUIT_SENT;
          default: ;
        endcase
      end
      REQ_USER: begin
        if (state_q == ST_CONNECTED) begin
          rsp_new.req_accepted = 1'b1;
          case (fccf_ucmd_e'(req_i.user_cmd))
            UCMD_LIST: state_d = ST_SEND_NLST;
            UCMD_GET:  state_d = ST_SEND_RETR;
            UCMD_CWD:  state_d = ST_SEND_CWD;
            UCMD_CDUP: state_d = ST_SEND_CDUP;
            default:   state_d = ST_SEND_NLST;
          endcase
        end
      end
      REQ_LOST: state_d = ST_NONE;
      default: ;
    endcase

    cmd                  = cmd_for_state(state_d);
    rsp_new.pending_cmd  = cmd;
    rsp_new.option_index = (cmd == CMD_OPTION) ? opt_sent_d : 3'd0;
    rsp_new.proto_state  = state_d;
    rsp_new.data_port    = port_d;
    rsp_new.line_done    = line.line_done;
    rsp_new.reply_code   = line.reply_code;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INITIAL;
      opt_sent_q <= 3'd0;
      rdy_rep_q  <= 1'b0;
    end else if (accept) begin
      state_q    <= state_d;
      opt_sent_q <= opt_sent_d;
      rdy_rep_q  <= rdy_rep_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_q    <= PORT_RESET;
      opt_cnt_q <= OPT_CNT_RESET;
    end else if (cfg_we_i) begin
      case (fccf_cfg_e'(cfg_idx_i))
        CFG_DATA_PORT_BASE: port_q    <= cfg_wdata_i[15:0];
        CFG_OPTION_COUNT:   opt_cnt_q <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end else if (accept) begin
      port_q <= port_d;
    end
  end

  // Result register with a skid entry behind it.
  assign pop = out_v_q && rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (pop) begin
        skid_v_q <= 1'b0;
      end
    end else if (accept) begin
      if (out_v_q && !pop) begin
        skid_v_q <= 1'b1;
      end else begin
        out_v_q <= 1'b1;
      end
    end else if (pop) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (pop) out_q <= skid_q;
    end else if (accept) begin
      if (out_v_q && !pop) begin
        skid_q <= rsp_new;
      end else begin
        out_q <= rsp_new;
      end
    end
  end

  assign rsp_o.valid           = out_v_q;
  assign rsp_o.pending_cmd     = out_q.pending_cmd;
  assign rsp_o.option_index    = out_q.option_index;
  assign rsp_o.proto_state     = out_q.proto_state;
  assign rsp_o.data_port       = out_q.data_port;
  assign rsp_o.line_done       = out_q.line_done;
  assign rsp_o.reply_code      = out_q.reply_code;
  assign rsp_o.connected_event = out_q.connected_event;
  assign rsp_o.cwd_done_event  = out_q.cwd_done_event;
  assign rsp_o.list_end_event  = out_q.list_end_event;
  assign rsp_o.req_accepted    = out_q.req_accepted;

endmodule

// ===== hdl/fccf_reply.sv =====
// Reply line capture: stores the first three bytes and forms the reply code.
module fccf_reply import fccf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_vld_i,
  input  logic [7:0] rx_byte_i,
  input  logic       clear_i,
  output fccf_line_t line_o
);

  logic [7:0]         byte_q [3];
  logic [7:0]         byte_d [3];
  logic [1:0]         count_q, count_d;
  logic               store;
  logic               is_lf;
  logic signed [9:0]  dig0, dig1, dig2;
  logic signed [16:0] sum;

  assign store = byte_vld_i && (count_q != 2'd3);
  assign is_lf = byte_vld_i && (rx_byte_i == LF_BYTE);

  always_comb begin
    byte_d = byte_q;
    if (store) begin
      byte_d[count_q] = rx_byte_i;
    end
  end

  // The code uses this byte too when it lands in one of the first three slots.
  always_comb begin
    dig0 = $signed({2'b00, byte_d[0]}) - $signed({2'b00, ASCII_ZERO});
    dig1 = $signed({2'b00, byte_d[1]}) - $signed({2'b00, ASCII_ZERO});
    dig2 = $signed({2'b00, byte_d[2]}) - $signed({2'b00, ASCII_ZERO});
    sum  = 17'(dig0) * 17'sd100 + 17'(dig1) * 17'sd10 + 17'(dig2);
  end

  always_comb begin
    count_d = count_q;
    if (clear_i || is_lf) begin
      count_d = 2'd0;
    end else if (store) begin
      count_d = count_q + 2'd1;
    end
  end

  assign line_o.line_done  = is_lf;
  assign line_o.reply_code = is_lf ? $signed(sum[15:0]) : 16'sd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= 2'd0;
      byte_q[0] <= 8'd0;
      byte_q[1] <= 8'd0;
      byte_q[2] <= 8'd0;
    end else begin
      count_q <= count_d;
      byte_q  <= byte_d;
    end
  end

endmodule

// ===== hdl/fccf_checker.sv =====
// Port-level checks of the FTP client control engine, bound to the top level.
`include "ftp_client_control_fsm_macros.svh"

module fccf_checker import fccf_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic [3:0]         pending_cmd,
  input logic [4:0]         proto_state,
  input logic               line_done,
  input logic signed [15:0] reply_code,
  input logic               connected_event,
  input logic               cwd_done_event,
  input logic               list_end_event
);

  // hold a stalled result
  `FCCF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(proto_state) && $stable(reply_code))

  // an empty result register never blocks requests
  `FCCF_ASSERT_IMPL(a_req_open, !rsp_valid, req_ready)

  // events and codes appear only with the end of a reply line
  `FCCF_ASSERT_IMPL(a_evt_line, rsp_valid && !line_done, reply_code == 16'sd0 && !connected_event && !cwd_done_event && !list_end_event)

  // a refused transfer always leaves a new PORT due
  `FCCF_ASSERT_IMPL(a_list_port, rsp_valid && list_end_event, pending_cmd == CMD_PORT && proto_state == ST_SEND_PORT)

  // the session reports readiness once per reset
  `FCCF_ASSERT_NEXT(a_conn_once, rsp_valid && rsp_ready && connected_event, !(rsp_valid && connected_event))

endmodule

bind ftp_client_control_fsm fccf_checker u_fccf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_ready       (req_i.ready),
  .rsp_valid       (rsp_o.valid),
  .rsp_ready       (rsp_o.ready),
  .pending_cmd     (rsp_o.pending_cmd),
  .proto_state     (rsp_o.proto_state),
  .line_done       (rsp_o.line_done),
  .reply_code      (rsp_o.reply_code),
  .connected_event (rsp_o.connected_event),
  .cwd_done_event  (rsp_o.cwd_done_event),
  .list_end_event  (rsp_o.list_end_event)
);

// ===== sim/tb_top.sv =====
// Self-checking testbench for the FTP client control engine: directed and random sessions.
`timescale 1ns / 100ps

module tb_top;
  import fccf_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 570;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam logic [7:0]  CR_BYTE      = 8'h0d;

  // Replies that carry no special meaning for the engine.
  localparam int unsigned REPLY_OK         = 200;
  localparam int unsigned REPLY_FILE_OK    = 250;
  localparam int unsigned REPLY_CLOSING    = 421;
  localparam int unsigned REPLY_NOT_LOGGED = 530;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  fccf_req_if req_ch ();
  fccf_rsp_if rsp_ch ();

  ftp_client_control_fsm DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Session model
  fccf_state_e ses_state;
  logic [7:0]  line_bytes [3];
  logic [1:0]  byte_cnt;
  logic [2:0]  opt_sent;
  logic [2:0]  opt_limit;
  logic [15:0] cur_port;
  logic        ready_seen;

  fccf_rsp_t   predicted_status [$];
  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned stall_cycles = 0;
  bit          src_quiet = 1'b0;
  bit          snk_quiet = 1'b0;

  function automatic fccf_rsp_t advance_session(logic [1:0] kind, logic [7:0] rxb,
                                                logic [1:0] ucmd);
    fccf_rsp_t st;
    int        code;
    st = '0;
    case (kind)
      REQ_BYTE: begin
        if (byte_cnt < 2'd3) begin
          line_bytes[byte_cnt] = rxb;
          byte_cnt = byte_cnt + 2'd1;
        end
        if (rxb == LF_BYTE) begin
          code = (int'(line_bytes[0]) - int'(ASCII_ZERO)) * 100 +
                 (int'(line_bytes[1]) - int'(ASCII_ZERO)) * 10 +
                 (int'(line_bytes[2]) - int'(ASCII_ZERO));
          st.line_done  = 1'b1;
          st.reply_code = code[15:0];
          case (ses_state)
            ST_INITIAL: begin
              if (code == int'(CODE_SVC_READY)) ses_state = ST_SEND_USER;
            end
            ST_USER_SENT: begin
              if (code == int'(CODE_NEED_PASS)) ses_state = ST_SEND_PASS;
            end
            ST_PASS_SENT: begin
              if (code == int'(CODE_LOGGED_IN)) begin
                ses_state = ST_SEND_OPT;
                opt_sent  = 3'd0;
              end
            end
            ST_PORT_SENT: begin
              ses_state = ST_CONNECTED;
              if (!ready_seen) begin
                st.connected_event = 1'b1;
                ready_seen = 1'b1;
              end
            end
            ST_OPT_SENT: begin
              if (opt_sent >= opt_limit) ses_state = ST_SEND_PORT;
              else ses_state = ST_SEND_OPT;
            end
            ST_NLST_SENT, ST_RETR_SENT, ST_CONNECTED: begin
              if (code == int'(CODE_XFER_DONE) || code == int'(CODE_NO_FILE)) begin
                cur_port  = cur_port + 16'd1;
                ses_state = ST_SEND_PORT;
              end
              if (code == int'(CODE_NO_FILE)) st.list_end_event = 1'b1;
            end
            ST_CWD_SENT, ST_CDUP_SENT: begin
              ses_state = ST_CONNECTED;
              st.cwd_done_event = 1'b1;
            end
            default: ;
          endcase
          byte_cnt = 2'd0;
        end
      end
      REQ_ACK: begin
        case (ses_state)
          ST_SEND_USER: ses_state = ST_USER_SENT;
          ST_SEND_PASS: ses_state = ST_PASS_SENT;
          ST_SEND_PORT: ses_state = ST_PORT_SENT;
          ST_SEND_OPT: begin
            opt_sent  = opt_sent + 3'd1;
            ses_state = ST_OPT_SENT;
          end
          ST_SEND_NLST: ses_state = ST_NLST_SENT;
          ST_SEND_RETR: ses_state = ST_RETR_SENT;
          ST_SEND_CWD:  ses_state = ST_CWD_SENT;
          ST_SEND_CDUP: ses_state = ST_CDUP_SENT;
          ST_SEND_QUIT: ses_state = ST_QUIT_SENT;
          default: ;
        endcase
      end
      REQ_USER: begin
        if (ses_state == ST_CONNECTED) begin
          case (ucmd)
            UCMD_LIST: ses_state = ST_SEND_NLST;
            UCMD_GET:  ses_state = ST_SEND_RETR;
            UCMD_CWD:  ses_state = ST_SEND_CWD;
            default:   ses_state = ST_SEND_CDUP;
          endcase
          st.req_accepted = 1'b1;
        end
      end
      default: begin
        ses_state = ST_NONE;
        byte_cnt  = 2'd0;
      end
    endcase
    case (ses_state)
      ST_SEND_USER: st.pending_cmd = CMD_USER;
      ST_SEND_PASS: st.pending_cmd = CMD_PASS;
      ST_SEND_PORT: st.pending_cmd = CMD_PORT;
      ST_SEND_OPT:  st.pending_cmd = CMD_OPTION;
      ST_SEND_NLST: st.pending_cmd = CMD_NLST;
      ST_SEND_RETR: st.pending_cmd = CMD_RETR;
      ST_SEND_CWD:  st.pending_cmd = CMD_CWD;
      ST_SEND_CDUP: st.pending_cmd = CMD_CDUP;
      default:      st.pending_cmd = CMD_NONE;
    endcase
    if (st.pending_cmd == CMD_OPTION) st.option_index = opt_sent;
    st.proto_state = ses_state;
    st.data_port   = cur_port;
    return st;
  endfunction

  function automatic string status_text(fccf_rsp_t s);
    return $sformatf("cmd=%0d opt=%0d state=%0d port=%0d line=%0b code=%0d ev=%0b%0b%0b acc=%0b",
                     s.pending_cmd, s.option_index, s.proto_state, s.data_port, s.line_done,
                     s.reply_code, s.connected_event, s.cwd_done_event, s.list_end_event,
                     s.req_accepted);
  endfunction

  task automatic check_status();
    fccf_rsp_t got;
    fccf_rsp_t want;
    got.pending_cmd     = rsp_ch.pending_cmd;
    got.option_index    = rsp_ch.option_index;
    got.proto_state     = rsp_ch.proto_state;
    got.data_port       = rsp_ch.data_port;
    got.line_done       = rsp_ch.line_done;
    got.reply_code      = rsp_ch.reply_code;
    got.connected_event = rsp_ch.connected_event;
    got.cwd_done_event  = rsp_ch.cwd_done_event;
    got.list_end_event  = rsp_ch.list_end_event;
    got.req_accepted    = rsp_ch.req_accepted;
    if (predicted_status.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("unexpected status: %s", status_text(got));
    end else begin
      want = predicted_status.pop_front();
      if (got.pending_cmd !== want.pending_cmd || got.option_index !== want.option_index ||
          got.proto_state !== want.proto_state || got.data_port !== want.data_port ||
          got.line_done !== want.line_done || got.reply_code !== want.reply_code ||
          got.connected_event !== want.connected_event ||
          got.cwd_done_event !== want.cwd_done_event ||
          got.list_end_event !== want.list_end_event ||
          got.req_accepted !== want.req_accepted) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("status mismatch at %0t", $realtime);
          $display("  expected %s", status_text(want));
          $display("  actual   %s", status_text(got));
        end
      end
    end
  endtask

  // Predict on every accepted request, check every accepted status.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
        predicted_status.push_back(advance_session(req_ch.req_type, req_ch.rx_byte,
                                                   req_ch.user_cmd));
      if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) check_status();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic int unsigned draw_pause(bit quiet);
    return quiet ? 0 : $urandom_range(11, 0);
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255, 0));
    return (b == LF_BYTE) ? ~b : b;
  endfunction

  // Switch between paced and back-to-back stretches on both sides.
  initial begin : pace_shift
    forever begin
      repeat ($urandom_range(300, 60)) @(posedge clk_i);
      src_quiet <= ($urandom_range(3, 0) == 0);
      snk_quiet <= ($urandom_range(3, 0) == 0);
    end
  end

  initial begin : status_sink
    int unsigned stall;
    rsp_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_pause(snk_quiet);
      if (stall != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1));
    end
  end

  // Hold valid high across back-to-back requests.
  task automatic send_item(fccf_req_e kind, logic [7:0] rxb, logic [1:0] ucmd);
    int unsigned pause;
    pause = draw_pause(src_quiet);
    if (pause != 0) begin
      req_ch.valid <= 1'b0;
      repeat (pause) @(posedge clk_i);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.rx_byte  <= rxb;
    req_ch.user_cmd <= ucmd;
    do @(posedge clk_i); while (req_ch.ready !== 1'b1);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_item(REQ_BYTE, b, 2'($urandom_range(3, 0)));
  endtask

  task automatic send_ack();
    send_item(REQ_ACK, 8'($urandom_range(255, 0)), 2'($urandom_range(3, 0)));
  endtask

  task automatic send_user(fccf_ucmd_e u);
    send_item(REQ_USER, 8'($urandom_range(255, 0)), u);
  endtask

  task automatic send_lost();
    send_item(REQ_LOST, 8'($urandom_range(255, 0)), 2'($urandom_range(3, 0)));
  endtask

  // Three digits, optional text and CR, then the line feed.
  task automatic send_reply(int unsigned code, bit chatty);
    int unsigned fill;
    send_byte(ASCII_ZERO + 8'(code / 100));
    send_byte(ASCII_ZERO + 8'((code / 10) % 10));
    send_byte(ASCII_ZERO + 8'(code % 10));
    if (chatty) begin
      fill = $urandom_range(5, 0);
      repeat (fill) send_byte(text_byte());
      if ($urandom_range(1, 0) == 1) send_byte(CR_BYTE);
    end
    send_byte(LF_BYTE);
  endtask

  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (predicted_status.size() != 0);
  endtask

  task automatic write_reg(fccf_cfg_e idx, logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_DATA_PORT_BASE) cur_port = val;
    else opt_limit = val[2:0];
    @(posedge clk_i);
  endtask

  task automatic test_reply_capture();
    // Ignored in the initial state; shows the reset port.
    send_ack();
    send_user(UCMD_GET);
    repeat (3) send_byte(8'h00);
    send_byte(LF_BYTE);
    repeat (3) send_byte(8'hff);
    send_byte(LF_BYTE);
    // Bytes past the third are dropped.
    send_byte(ASCII_ZERO + 8'd1);
    send_byte(ASCII_ZERO + 8'd2);
    send_byte(ASCII_ZERO + 8'd3);
    send_byte(8'h41);
    send_byte(8'hfe);
    send_byte(LF_BYTE);
    // Short lines reuse earlier bytes.
    send_byte(ASCII_ZERO + 8'd9);
    send_byte(LF_BYTE);
    send_byte(LF_BYTE);
  endtask

  task automatic test_login();
    wait_idle();
    write_reg(CFG_DATA_PORT_BASE, 16'hffff);
    write_reg(CFG_OPTION_COUNT, 16'd7);
    send_reply(REPLY_CLOSING, 1'b1);
    send_reply(CODE_SVC_READY, 1'b1);
    send_ack();
    send_ack();
    send_reply(REPLY_NOT_LOGGED, 1'b0);
    send_reply(CODE_NEED_PASS, 1'b1);
    send_ack();
    send_reply(CODE_LOGGED_IN, 1'b1);
    repeat (7) begin
      send_ack();
      send_reply(REPLY_OK, 1'b1);
    end
    send_ack();
    send_user(UCMD_LIST);
    send_reply(REPLY_OK, 1'b1);
  endtask

  task automatic run_request_cycle();
    fccf_ucmd_e  u;
    int unsigned pick;
    u = fccf_ucmd_e'($urandom_range(3, 0));
    pick = $urandom_range(9, 0);
    send_user(u);
    send_ack();
    if (u == UCMD_CWD || u == UCMD_CDUP) begin
      if (pick < 5) send_reply(REPLY_FILE_OK, 1'b1);
      else if (pick < 8) send_reply(CODE_NO_FILE, 1'b1);
      else send_reply($urandom_range(999, 0), 1'b1);
    end else begin
      if (pick < 4) send_reply(CODE_XFER_DONE, 1'b1);
      else if (pick < 8) send_reply(CODE_NO_FILE, 1'b1);
      else send_reply($urandom_range(999, 0), 1'b1);
      send_ack();
      if ($urandom_range(3, 0) != 0) send_reply(REPLY_OK, 1'b1);
      else send_reply($urandom_range(999, 0), 1'b0);
    end
  endtask

  task automatic run_noise();
    case ($urandom_range(5, 0))
      0: send_byte(8'($urandom_range(255, 0)));
      1: send_ack();
      2: send_user(fccf_ucmd_e'($urandom_range(3, 0)));
      3: begin
        repeat (3) send_byte(text_byte());
        send_byte(LF_BYTE);
      end
      4: begin
        if ($urandom_range(1, 0) == 1) send_byte(text_byte());
        send_byte(LF_BYTE);
      end
      default: begin
        case ($urandom_range(3, 0))
          0: send_reply(CODE_XFER_DONE, 1'b0);
          1: send_reply(CODE_NO_FILE, 1'b1);
          2: send_reply(REPLY_OK, 1'b1);
          default: send_reply($urandom_range(999, 0), 1'b1);
        endcase
      end
    endcase
  endtask

  task automatic retune(int unsigned phase);
    wait_idle();
    case (phase % 4)
      0: begin
        write_reg(CFG_DATA_PORT_BASE, 16'h0000);
        write_reg(CFG_OPTION_COUNT, 16'd1);
      end
      1: begin
        write_reg(CFG_DATA_PORT_BASE, 16'hffff);
        write_reg(CFG_OPTION_COUNT, 16'd7);
      end
      default: begin
        write_reg(CFG_DATA_PORT_BASE, 16'($urandom_range(65535, 0)));
        write_reg(CFG_OPTION_COUNT, 16'($urandom_range(7, 1)));
      end
    endcase
  endtask

  task automatic test_random_session();
    int unsigned stop_at;
    int unsigned steps;
    stop_at = items_sent + RANDOM_ITEMS;
    steps = 0;
    while (items_sent < stop_at) begin
      if (steps % 30 == 29) retune(steps / 30);
      if ($urandom_range(4, 0) == 0) run_noise();
      else run_request_cycle();
      steps++;
    end
  endtask

  task automatic test_connection_lost();
    send_byte(ASCII_ZERO + 8'd5);
    send_byte(ASCII_ZERO + 8'd5);
    send_lost();
    // Lines are still captured, nothing else moves the state.
    send_reply(CODE_NO_FILE, 1'b0);
    send_ack();
    send_user(UCMD_LIST);
    send_lost();
    send_byte(LF_BYTE);
  endtask

  initial begin
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_BYTE;
    req_ch.rx_byte  <= 8'h00;
    req_ch.user_cmd <= UCMD_LIST;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= CFG_DATA_PORT_BASE;
    cfg_wdata_i     <= '0;
    ses_state  = ST_INITIAL;
    line_bytes = '{8'h00, 8'h00, 8'h00};
    byte_cnt   = 2'd0;
    opt_sent   = 3'd0;
    opt_limit  = OPT_CNT_RESET;
    cur_port   = PORT_RESET;
    ready_seen = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reply_capture();
    test_login();
    test_random_session();
    test_connection_lost();

    wait_idle();
    repeat (4) @(posedge clk_i);
    if (predicted_status.size() != 0) begin
      $display("%0d expected status records never arrived", predicted_status.size());
      mismatch_count += predicted_status.size();
    end
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/fccf_pkg.sv
hdl/fccf_if.sv
hdl/fccf_reply.sv
hdl/ftp_client_control_fsm.sv
hdl/fccf_checker.sv
sim/tb_top.sv
